### sv/msrs_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the serial mouse report shifter
// no dependencies; used by msrs_axis_delta and the core top level

package msrs_pkg;

    localparam int POS_W   = 9;
    localparam int DELTA_W = 8;
    localparam int MAG_W   = DELTA_W - 1;
    localparam int IDX_W   = 6;

    localparam logic [MAG_W-1:0] MAG_MAX = 7'h7f;

    // action codes
    localparam logic ACT_STROBE = 1'b0;
    localparam logic ACT_READ   = 1'b1;

    // report layout, by bit index
    localparam logic [IDX_W-1:0] IDX_RIGHT    = 6'd8;
    localparam logic [IDX_W-1:0] IDX_LEFT     = 6'd9;
    localparam logic [IDX_W-1:0] IDX_SPEED_HI = 6'd10;
    localparam logic [IDX_W-1:0] IDX_SPEED_LO = 6'd11;
    localparam logic [IDX_W-1:0] IDX_SIG      = 6'd15;
    localparam logic [IDX_W-1:0] IDX_Y_FIRST  = 6'd16;
    localparam logic [IDX_W-1:0] IDX_Y_LAST   = 6'd23;
    localparam logic [IDX_W-1:0] IDX_X_FIRST  = 6'd24;
    localparam logic [IDX_W-1:0] IDX_X_LAST   = 6'd31;
    localparam logic [IDX_W-1:0] IDX_DONE     = 6'd32;

    localparam logic [1:0] SPEED_LAST = 2'd2;

    typedef struct packed {
        logic             action;
        logic             strobe_value;
        logic             button_left;
        logic             button_right;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
    } t_in_item;

endpackage

### sv/msrs_axis_delta.sv
`timescale 1ns / 1ps
// one axis of the report: clamped magnitude of the position change plus sticky sign
// depends on msrs_pkg

module msrs_axis_delta (
    input  logic [msrs_pkg::POS_W-1:0]   i_now,
    input  logic [msrs_pkg::POS_W-1:0]   i_before,
    input  logic                         i_dir_neg,
    output logic                         o_dir_neg,
    output logic [msrs_pkg::DELTA_W-1:0] o_delta
);

    logic                       w_neg;
    logic [msrs_pkg::POS_W-1:0] w_mag;
    logic [msrs_pkg::MAG_W-1:0] w_mag_clamped;

    always_comb begin
        w_neg = (i_now < i_before);
        w_mag = w_neg ? (i_before - i_now) : (i_now - i_before);
        // clamp to 7 bits
        if (w_mag > msrs_pkg::POS_W'(msrs_pkg::MAG_MAX)) begin
            w_mag_clamped = msrs_pkg::MAG_MAX;
        end else begin
            w_mag_clamped = w_mag[msrs_pkg::MAG_W-1:0];
        end
        // sign sticks when there is no movement
        o_dir_neg = (i_now != i_before) ? w_neg : i_dir_neg;
        o_delta   = {o_dir_neg, w_mag_clamped};
    end

endmodule

### sv/mouse_serial_report_shifter_core.sv
`timescale 1ns / 1ps
// top level of the serial mouse report shifter: input register, report state, result register
// depends on msrs_pkg and msrs_axis_delta

// usage
//   input channel (i_in_valid / o_in_ready) carries one access: a strobe write
//   (i_action low, new level in i_strobe_value) or a data pin read (i_action high).
//   buttons and positions travel with every transfer and are sampled only by a
//   strobe write that takes the strobe level from 1 to 0.
//   output channel (o_out_valid / i_out_ready) carries one data bit per read;
//   strobe writes produce nothing.
// path: a transfer lands in the input register and is then processed against the
//   report state, which loads the result register that drives o_out_valid.
// throughput: one access per cycle while no read is stalled; the state update is a 9-bit
//   subtract and compare per axis plus a bit select, all in the single processing stage.
// stall: while the result register is full and i_out_ready is low, a pending
//   read waits in the input register; o_in_ready drops only then. strobe writes
//   pass through even while the output is stalled.
// reset (i_rst_n low, synchronous): both registers empty, strobe level low,
//   report cleared, speed mode 0, both direction flags set to negative.

module mouse_serial_report_shifter_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_action,
    input  logic                       i_strobe_value,
    input  logic                       i_button_left,
    input  logic                       i_button_right,
    input  logic [msrs_pkg::POS_W-1:0] i_pos_x,
    input  logic [msrs_pkg::POS_W-1:0] i_pos_y,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_data_bit
);

    // input register
    logic               r_in_valid, n_in_valid;
    msrs_pkg::t_in_item r_in, n_in;

    // report state
    logic                         r_strobe,    n_strobe;
    logic [msrs_pkg::IDX_W-1:0]   r_bit_index, n_bit_index;
    logic                         r_btn_left,  n_btn_left;
    logic                         r_btn_right, n_btn_right;
    logic [msrs_pkg::POS_W-1:0]   r_prev_x,    n_prev_x;
    logic [msrs_pkg::POS_W-1:0]   r_prev_y,    n_prev_y;
    logic [msrs_pkg::DELTA_W-1:0] r_delta_x,   n_delta_x;
    logic [msrs_pkg::DELTA_W-1:0] r_delta_y,   n_delta_y;
    logic [1:0]                   r_speed,     n_speed;
    logic                         r_dir_x_neg, n_dir_x_neg;
    logic                         r_dir_y_neg, n_dir_y_neg;

    // result register
    logic r_out_valid, n_out_valid;
    logic r_data_bit,  n_data_bit;

    logic                         w_is_read;
    logic                         w_advance;
    logic                         w_fall;
    logic                         w_dx_neg, w_dy_neg;
    logic [msrs_pkg::DELTA_W-1:0] w_dx, w_dy;
    logic                         w_report_bit;

    // per-axis deltas against the previous sample
    msrs_axis_delta u_delta_x (
        .i_now     (r_in.pos_x),
        .i_before  (r_prev_x),
        .i_dir_neg (r_dir_x_neg),
        .o_dir_neg (w_dx_neg),
        .o_delta   (w_dx)
    );

    msrs_axis_delta u_delta_y (
        .i_now     (r_in.pos_y),
        .i_before  (r_prev_y),
        .i_dir_neg (r_dir_y_neg),
        .o_dir_neg (w_dy_neg),
        .o_delta   (w_dy)
    );

    // a read needs room in the result register, a strobe write never waits
    assign w_is_read = (r_in.action == msrs_pkg::ACT_READ);
    assign w_advance = r_in_valid && (!w_is_read || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    assign w_fall = !w_is_read && r_strobe && !r_in.strobe_value;

    // report bit at the current index
    always_comb begin
        case (r_bit_index) inside
            msrs_pkg::IDX_RIGHT:    w_report_bit = r_btn_right;
            msrs_pkg::IDX_LEFT:     w_report_bit = r_btn_left;
            msrs_pkg::IDX_SPEED_HI: w_report_bit = r_speed[1];
            msrs_pkg::IDX_SPEED_LO: w_report_bit = r_speed[0];
            msrs_pkg::IDX_SIG:      w_report_bit = 1'b1;
            [msrs_pkg::IDX_Y_FIRST:msrs_pkg::IDX_Y_LAST]:
                w_report_bit = r_delta_y[~r_bit_index[2:0]];
            [msrs_pkg::IDX_X_FIRST:msrs_pkg::IDX_X_LAST]:
                w_report_bit = r_delta_x[~r_bit_index[2:0]];
            msrs_pkg::IDX_DONE:     w_report_bit = 1'b1;
            default:                w_report_bit = 1'b0;
        endcase
    end

    always_comb begin
        n_in_valid  = r_in_valid;
        n_in        = r_in;
        n_strobe    = r_strobe;
        n_bit_index = r_bit_index;
        n_btn_left  = r_btn_left;
        n_btn_right = r_btn_right;
        n_prev_x    = r_prev_x;
        n_prev_y    = r_prev_y;
        n_delta_x   = r_delta_x;
        n_delta_y   = r_delta_y;
        n_speed     = r_speed;
        n_dir_x_neg = r_dir_x_neg;
        n_dir_y_neg = r_dir_y_neg;
        n_out_valid = r_out_valid && !i_out_ready;
        n_data_bit  = r_data_bit;

        // input register load
        if (o_in_ready) begin
            n_in_valid         = i_in_valid;
            n_in.action        = i_action;
            n_in.strobe_value  = i_strobe_value;
            n_in.button_left   = i_button_left;
            n_in.button_right  = i_button_right;
            n_in.pos_x         = i_pos_x;
            n_in.pos_y         = i_pos_y;
        end

        if (w_advance) begin
            if (!w_is_read) begin
                n_strobe = r_in.strobe_value;
                // falling strobe latches a fresh report
                if (w_fall) begin
                    n_bit_index = '0;
                    n_btn_left  = r_in.button_left;
                    n_btn_right = r_in.button_right;
                    n_delta_x   = w_dx;
                    n_delta_y   = w_dy;
                    n_dir_x_neg = w_dx_neg;
                    n_dir_y_neg = w_dy_neg;
                    n_prev_x    = r_in.pos_x;
                    n_prev_y    = r_in.pos_y;
                end
            end else begin
                n_out_valid = 1'b1;
                if (r_strobe) begin
                    // read with strobe high cycles the speed mode
                    n_speed    = (r_speed == msrs_pkg::SPEED_LAST) ? 2'd0 : r_speed + 2'd1;
                    n_data_bit = 1'b0;
                end else begin
                    n_data_bit = w_report_bit;
                    if (r_bit_index != msrs_pkg::IDX_DONE) begin
                        n_bit_index = r_bit_index + 6'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_strobe    <= 1'b0;
            r_bit_index <= '0;
            r_btn_left  <= 1'b0;
            r_btn_right <= 1'b0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_delta_x   <= '0;
            r_delta_y   <= '0;
            r_speed     <= 2'd0;
            r_dir_x_neg <= 1'b1;
            r_dir_y_neg <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_strobe    <= n_strobe;
            r_bit_index <= n_bit_index;
            r_btn_left  <= n_btn_left;
            r_btn_right <= n_btn_right;
            r_prev_x    <= n_prev_x;
            r_prev_y    <= n_prev_y;
            r_delta_x   <= n_delta_x;
            r_delta_y   <= n_delta_y;
            r_speed     <= n_speed;
            r_dir_x_neg <= n_dir_x_neg;
            r_dir_y_neg <= n_dir_y_neg;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_in       <= n_in;
        r_data_bit <= n_data_bit;
    end

    assign o_out_valid = r_out_valid;
    assign o_data_bit  = r_data_bit;

    // checks
    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_speed != 2'd3)
        else $error("speed mode reached 3");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_index <= msrs_pkg::IDX_DONE)
        else $error("bit index past end of report");

    a_strobe_high_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_is_read && r_strobe) |=> (o_out_valid && !o_data_bit))
        else $error("read with strobe high did not return zero");

    a_exhausted_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_is_read && !r_strobe && r_bit_index == msrs_pkg::IDX_DONE)
        |=> (o_out_valid && o_data_bit && r_bit_index == msrs_pkg::IDX_DONE))
        else $error("exhausted report did not return one");

    a_fall_clears_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_fall) |=> (r_bit_index == '0 && !r_strobe))
        else $error("falling strobe did not restart the report");

endmodule
